// File: rtl/core/gtsp_pkg.sv
// ----------------------------------------------------------------------------
// gtsp_pkg
// types and constants shared by the tag stream parser and its channels
// ----------------------------------------------------------------------------
`default_nettype none

package gtsp_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned VADDR_W = 22;

  // size of the image memory in bytes
  localparam logic [32:0] VRAM_BYTES = 33'd4194304;
  localparam logic [32:0] QUAD_BYTES = 33'd16;

  typedef enum logic [2:0] {
    PH_TAG_LO = 3'd0,
    PH_TAG_HI = 3'd1,
    PH_PK_LO  = 3'd2,
    PH_PK_HI  = 3'd3,
    PH_RL     = 3'd4,
    PH_IM_LO  = 3'd5,
    PH_IM_HI  = 3'd6,
    PH_RL_PAD = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_REG    = 2'd0,
    KIND_VERTEX = 2'd1,
    KIND_IMAGE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FMT_PACKED  = 2'd0,
    FMT_REGLIST = 2'd1,
    FMT_IMAGE   = 2'd2,
    FMT_DISABLE = 2'd3
  } fmt_t;

  // packed-mode register descriptors with special handling
  localparam logic [3:0] DESC_XYZF2 = 4'h4;
  localparam logic [3:0] DESC_XYZ2  = 4'h5;
  localparam logic [3:0] DESC_FOG   = 4'hA;
  localparam logic [3:0] DESC_RSVD  = 4'hB;
  localparam logic [3:0] DESC_XYZF3 = 4'hC;
  localparam logic [3:0] DESC_XYZ3  = 4'hD;
  localparam logic [3:0] DESC_AD    = 4'hE;
  localparam logic [3:0] DESC_NOP   = 4'hF;

  localparam logic [7:0] REG_PRIM      = 8'h00;
  localparam logic [7:0] REG_FOG       = 8'h0A;
  localparam logic [7:0] REG_BITBLTBUF = 8'h50;

endpackage : gtsp_pkg

`default_nettype wire

// File: rtl/core/gtsp_word_if.sv
// ----------------------------------------------------------------------------
// gtsp_word_if
// packet stream channel: one 64-bit word per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface gtsp_word_if;
  logic                        valid;
  logic                        ready;
  logic [gtsp_pkg::WORD_W-1:0] word;
  logic                        last_of_buffer;

  modport source (output valid, output word, output last_of_buffer, input ready);
  modport sink   (input valid, input word, input last_of_buffer, output ready);
endinterface : gtsp_word_if

`default_nettype wire

// File: rtl/core/gtsp_event_if.sv
// ----------------------------------------------------------------------------
// gtsp_event_if
// result channel: register write, vertex event or image quad per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface gtsp_event_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [gtsp_pkg::ADDR_W-1:0]  reg_addr;
  logic [gtsp_pkg::WORD_W-1:0]  value;
  logic [gtsp_pkg::WORD_W-1:0]  value_hi;
  logic [gtsp_pkg::VADDR_W-1:0] vram_addr;

  modport source (output valid, output kind, output reg_addr, output value,
                  output value_hi, output vram_addr, input ready);
  modport sink   (input valid, input kind, input reg_addr, input value,
                  input value_hi, input vram_addr, output ready);
endinterface : gtsp_event_if

`default_nettype wire

// File: rtl/core/gif_tag_stream_parser_core.sv
// ----------------------------------------------------------------------------
// gif_tag_stream_parser_core
// parses tagged packet words into register writes, vertex events and image
// quad writes
// ----------------------------------------------------------------------------
// Takes one 64-bit stream word per clock and decodes it combinationally
// against the parser state; any result it causes lands in one output register
// and appears there in the cycle after its word is taken. A new word is taken
// whenever that output register is empty or is being drained in the same
// cycle, so the sustained rate is one word per cycle with no gaps while the
// result side keeps up. Tags are two words, packed and image quads two words,
// reglist entries one word. Words carrying last_of_buffer drop any partial
// tag, quad or remaining loops. Image writes that would run past the end of
// image memory are dropped, but still advance the address.
`default_nettype none

module gif_tag_stream_parser_core #(
  parameter logic [32:0] VRAM_BYTES = gtsp_pkg::VRAM_BYTES
) (
  input  wire logic     clk,
  input  wire logic     rst,
  gtsp_word_if.sink     stream,
  gtsp_event_if.source  events
);

  gtsp_pkg::phase_t phase, phase_next;
  logic [14:0]      loops_left, loops_left_next;
  logic [4:0]       regs_per_loop, regs_per_loop_next;
  logic [3:0]       reg_slot, reg_slot_next;
  logic [63:0]      reg_descriptors, reg_descriptors_next;
  logic [1:0]       data_format, data_format_next;
  logic [63:0]      held_low_word, held_low_word_next;
  logic [31:0]      image_address, image_address_next;
  logic             pad_pending, pad_pending_next;

  logic             out_valid;
  logic             in_acc;

  logic [3:0]       cur_desc;
  logic [3:0]       slot_inc;
  logic             slot_wrap;
  logic [14:0]      loops_dec;
  logic             loops_done;
  logic             image_fits;
  logic [3:0]       tag_nreg;
  logic [4:0]       tag_regs;
  logic [1:0]       tag_fmt;
  logic [14:0]      tag_loops;

  logic             res_valid;
  gtsp_pkg::kind_t  res_kind;
  logic [7:0]       res_addr;
  logic [63:0]      res_lo;
  logic [63:0]      res_hi;
  logic [21:0]      res_vaddr;
  logic             bitblt_load;

  assign stream.ready = !out_valid || events.ready;
  assign in_acc       = stream.valid && stream.ready;

  assign cur_desc   = reg_descriptors[{reg_slot, 2'b00} +: 4];
  assign slot_inc   = reg_slot + 4'd1;
  assign slot_wrap  = (slot_inc == 4'd0) || ({1'b0, slot_inc} >= regs_per_loop);
  assign loops_dec  = loops_left - 15'd1;
  assign loops_done = (loops_dec == 15'd0);
  assign image_fits = ({1'b0, image_address} + gtsp_pkg::QUAD_BYTES) <= VRAM_BYTES;

  assign tag_nreg  = held_low_word[63:60];
  assign tag_regs  = (tag_nreg == 4'd0) ? 5'd16 : {1'b0, tag_nreg};
  assign tag_fmt   = held_low_word[59:58];
  assign tag_loops = held_low_word[14:0];

  // result decode
  always_comb begin : result_decode
    res_valid = 1'b0;
    res_kind  = gtsp_pkg::KIND_REG;
    res_addr  = '0;
    res_lo    = '0;
    res_hi    = '0;
    res_vaddr = '0;
    unique case (phase)
      gtsp_pkg::PH_TAG_HI: begin
        if (held_low_word[46]) begin
          res_valid = 1'b1;
          res_addr  = gtsp_pkg::REG_PRIM;
          res_lo    = {53'd0, held_low_word[57:47]};
        end
      end
      gtsp_pkg::PH_PK_HI: begin
        unique case (cur_desc) inside
          gtsp_pkg::DESC_XYZF2, gtsp_pkg::DESC_XYZ2,
          gtsp_pkg::DESC_XYZF3, gtsp_pkg::DESC_XYZ3: begin
            res_valid = 1'b1;
            res_kind  = gtsp_pkg::KIND_VERTEX;
            res_addr  = {4'd0, cur_desc};
            res_lo    = held_low_word;
            res_hi    = stream.word;
          end
          gtsp_pkg::DESC_FOG: begin
            res_valid = 1'b1;
            res_addr  = gtsp_pkg::REG_FOG;
            res_lo    = {56'd0, stream.word[39:32]};
          end
          gtsp_pkg::DESC_AD: begin
            res_valid = 1'b1;
            res_addr  = stream.word[7:0];
            res_lo    = held_low_word;
          end
          gtsp_pkg::DESC_RSVD, gtsp_pkg::DESC_NOP: begin
            res_valid = 1'b0;
          end
          default: begin
            res_valid = 1'b1;
            res_addr  = {4'd0, cur_desc};
            res_lo    = held_low_word;
          end
        endcase
      end
      gtsp_pkg::PH_RL: begin
        res_valid = 1'b1;
        res_addr  = {4'd0, cur_desc};
        res_lo    = stream.word;
      end
      gtsp_pkg::PH_IM_HI: begin
        if (image_fits) begin
          res_valid = 1'b1;
          res_kind  = gtsp_pkg::KIND_IMAGE;
          res_lo    = held_low_word;
          res_hi    = stream.word;
          res_vaddr = image_address[21:0];
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  assign bitblt_load = res_valid && (res_kind == gtsp_pkg::KIND_REG)
                       && (res_addr == gtsp_pkg::REG_BITBLTBUF);

  // next state
  always_comb begin : state_next
    phase_next           = phase;
    loops_left_next      = loops_left;
    regs_per_loop_next   = regs_per_loop;
    reg_slot_next        = reg_slot;
    reg_descriptors_next = reg_descriptors;
    data_format_next     = data_format;
    held_low_word_next   = held_low_word;
    image_address_next   = image_address;
    pad_pending_next     = pad_pending;
    unique case (phase)
      gtsp_pkg::PH_TAG_LO: begin
        held_low_word_next = stream.word;
        phase_next         = gtsp_pkg::PH_TAG_HI;
      end
      gtsp_pkg::PH_TAG_HI: begin
        loops_left_next      = tag_loops;
        regs_per_loop_next   = tag_regs;
        data_format_next     = tag_fmt;
        reg_descriptors_next = stream.word;
        reg_slot_next        = 4'd0;
        pad_pending_next     = tag_loops[0] && tag_regs[0];
        if (tag_loops == 15'd0) begin
          phase_next = gtsp_pkg::PH_TAG_LO;
        end else if (tag_fmt == gtsp_pkg::FMT_IMAGE || tag_fmt == gtsp_pkg::FMT_DISABLE) begin
          phase_next = gtsp_pkg::PH_IM_LO;
        end else if (tag_fmt == gtsp_pkg::FMT_REGLIST) begin
          phase_next = gtsp_pkg::PH_RL;
        end else begin
          phase_next = gtsp_pkg::PH_PK_LO;
        end
      end
      gtsp_pkg::PH_PK_LO: begin
        held_low_word_next = stream.word;
        phase_next         = gtsp_pkg::PH_PK_HI;
      end
      gtsp_pkg::PH_PK_HI: begin
        if (bitblt_load) begin
          image_address_next = {7'd0, res_lo[45:32], 11'd0};
        end
        reg_slot_next = slot_wrap ? 4'd0 : slot_inc;
        if (slot_wrap) begin
          loops_left_next = loops_dec;
        end
        phase_next = (slot_wrap && loops_done) ? gtsp_pkg::PH_TAG_LO : gtsp_pkg::PH_PK_LO;
      end
      gtsp_pkg::PH_RL: begin
        reg_slot_next = slot_wrap ? 4'd0 : slot_inc;
        if (slot_wrap) begin
          loops_left_next = loops_dec;
        end
        if (slot_wrap && loops_done) begin
          phase_next = pad_pending ? gtsp_pkg::PH_RL_PAD : gtsp_pkg::PH_TAG_LO;
        end
      end
      gtsp_pkg::PH_IM_LO: begin
        held_low_word_next = stream.word;
        phase_next         = gtsp_pkg::PH_IM_HI;
      end
      gtsp_pkg::PH_IM_HI: begin
        image_address_next = image_address + 32'd16;
        loops_left_next    = loops_dec;
        phase_next         = loops_done ? gtsp_pkg::PH_TAG_LO : gtsp_pkg::PH_IM_LO;
      end
      gtsp_pkg::PH_RL_PAD: begin
        pad_pending_next = 1'b0;
        phase_next       = gtsp_pkg::PH_TAG_LO;
      end
      default: begin
        phase_next = gtsp_pkg::PH_TAG_LO;
      end
    endcase
    if (stream.last_of_buffer) begin
      phase_next = gtsp_pkg::PH_TAG_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= gtsp_pkg::PH_TAG_LO;
      loops_left      <= '0;
      regs_per_loop   <= '0;
      reg_slot        <= '0;
      reg_descriptors <= '0;
      data_format     <= '0;
      held_low_word   <= '0;
      image_address   <= '0;
      pad_pending     <= 1'b0;
    end else if (in_acc) begin
      phase           <= phase_next;
      loops_left      <= loops_left_next;
      regs_per_loop   <= regs_per_loop_next;
      reg_slot        <= reg_slot_next;
      reg_descriptors <= reg_descriptors_next;
      data_format     <= data_format_next;
      held_low_word   <= held_low_word_next;
      image_address   <= image_address_next;
      pad_pending     <= pad_pending_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= res_valid;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      events.kind      <= res_kind;
      events.reg_addr  <= res_addr;
      events.value     <= res_lo;
      events.value_hi  <= res_hi;
      events.vram_addr <= res_vaddr;
    end
  end

  assign events.valid = out_valid;

`ifndef NO_ASSERTIONS
  a_last_returns_to_tag : assert property (@(posedge clk) disable iff (rst)
    in_acc && stream.last_of_buffer |=> phase == gtsp_pkg::PH_TAG_LO)
    else $error("buffer end did not return parser to tag state");

  a_result_from_beat : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_acc))
    else $error("result appeared without an accepted beat");

  a_slot_in_range : assert property (@(posedge clk) disable iff (rst)
    (phase == gtsp_pkg::PH_PK_LO || phase == gtsp_pkg::PH_PK_HI || phase == gtsp_pkg::PH_RL)
    |-> ({1'b0, reg_slot} < regs_per_loop))
    else $error("descriptor slot beyond register count");

  a_loops_nonzero : assert property (@(posedge clk) disable iff (rst)
    (phase == gtsp_pkg::PH_PK_LO || phase == gtsp_pkg::PH_PK_HI || phase == gtsp_pkg::PH_RL
     || phase == gtsp_pkg::PH_IM_LO || phase == gtsp_pkg::PH_IM_HI)
    |-> (loops_left != 15'd0))
    else $error("data phase with no loops left");

  a_image_aligned : assert property (@(posedge clk) disable iff (rst)
    out_valid && events.kind == gtsp_pkg::KIND_IMAGE |-> events.vram_addr[3:0] == 4'd0)
    else $error("image quad address not quad aligned");
`endif

endmodule : gif_tag_stream_parser_core

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the gif tag stream parser core
// ----------------------------------------------------------------------------
// Feeds packet words as tags with packed, reglist and image data, zero-loop
// tags, cut-short packets and noise. Every accepted word goes through a
// behavioural parser that predicts the register writes, vertex events and
// image quad writes, which are then matched in order against the result
// channel. Both sides idle at varying rates, and the receiver holds off once
// for a long stretch so that the core fills up and stalls its input.
// ----------------------------------------------------------------------------

module testbench;

  localparam int RANDOM_CHUNK = 45;
  localparam int STALL_CYCLES = 120;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [63:0] data;
    logic        last;
  } stream_beat_t;

  typedef struct {
    gtsp_pkg::kind_t kind;
    logic [7:0]      reg_addr;
    logic [63:0]     value;
    logic [63:0]     value_hi;
    logic [21:0]     vram_addr;
  } event_rec_t;

  logic clk = 1'b0;
  logic rst;

  gtsp_word_if  word_ch ();
  gtsp_event_if event_ch ();

  gif_tag_stream_parser_core dut (
    .clk    (clk),
    .rst    (rst),
    .stream (word_ch),
    .events (event_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stream_beat_t words_to_send[$];
  event_rec_t   awaited_events[$];

  int send_idle_pct;
  int recv_idle_pct;
  logic stall_request;
  logic word_taken  = 1'b0;
  logic all_settled = 1'b0;
  int words_queued  = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  // run statistics
  int words_parsed  = 0;
  int reg_writes    = 0;
  int vertex_events = 0;
  int image_writes  = 0;
  int quads_dropped = 0;
  int buffer_ends   = 0;

  // parser state as predicted
  gtsp_pkg::phase_t parse_phase  = gtsp_pkg::PH_TAG_LO;
  logic [14:0]      loops_to_go  = '0;
  logic [4:0]       regs_in_loop = '0;
  logic [3:0]       slot         = '0;
  logic [63:0]      descriptors  = '0;
  gtsp_pkg::fmt_t   data_fmt     = gtsp_pkg::FMT_PACKED;
  logic [63:0]      held_word    = '0;
  logic [31:0]      image_ptr    = '0;
  logic             pad_owed     = 1'b0;

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s", $time, msg);
  endtask

  function automatic void expect_event(gtsp_pkg::kind_t k, logic [7:0] a, logic [63:0] lo,
                                       logic [63:0] hi, logic [21:0] va);
    event_rec_t e;
    e.kind      = k;
    e.reg_addr  = a;
    e.value     = lo;
    e.value_hi  = hi;
    e.vram_addr = va;
    awaited_events.push_back(e);
    case (k)
      gtsp_pkg::KIND_REG:    reg_writes++;
      gtsp_pkg::KIND_VERTEX: vertex_events++;
      default:               image_writes++;
    endcase
  endfunction

  function automatic void expect_reg_write(logic [7:0] a, logic [63:0] v);
    if (a == gtsp_pkg::REG_BITBLTBUF)
      image_ptr = {7'd0, v[45:32], 11'd0};
    expect_event(gtsp_pkg::KIND_REG, a, v, '0, '0);
  endfunction

  // moves to the next descriptor, true once the final loop is through
  function automatic logic step_descriptor();
    slot = slot + 4'd1;
    if (slot == 4'd0 || {1'b0, slot} >= regs_in_loop) begin
      slot = 4'd0;
      loops_to_go = loops_to_go - 15'd1;
      return loops_to_go == 15'd0;
    end
    return 1'b0;
  endfunction

  function automatic void parse_stream_word(logic [63:0] w, logic last);
    logic [3:0] desc;
    logic [3:0] nreg;
    desc = descriptors[slot * 4 +: 4];
    words_parsed++;
    case (parse_phase)
      gtsp_pkg::PH_TAG_LO: begin
        held_word = w;
        parse_phase = gtsp_pkg::PH_TAG_HI;
      end
      gtsp_pkg::PH_TAG_HI: begin
        nreg = held_word[63:60];
        loops_to_go = held_word[14:0];
        regs_in_loop = (nreg == 4'd0) ? 5'd16 : {1'b0, nreg};
        data_fmt = gtsp_pkg::fmt_t'(held_word[59:58]);
        descriptors = w;
        slot = 4'd0;
        pad_owed = loops_to_go[0] & regs_in_loop[0];
        if (held_word[46])
          expect_reg_write(gtsp_pkg::REG_PRIM, {53'd0, held_word[57:47]});
        if (loops_to_go == 15'd0)
          parse_phase = gtsp_pkg::PH_TAG_LO;
        else if (data_fmt == gtsp_pkg::FMT_IMAGE || data_fmt == gtsp_pkg::FMT_DISABLE)
          parse_phase = gtsp_pkg::PH_IM_LO;
        else if (data_fmt == gtsp_pkg::FMT_REGLIST)
          parse_phase = gtsp_pkg::PH_RL;
        else
          parse_phase = gtsp_pkg::PH_PK_LO;
      end
      gtsp_pkg::PH_PK_LO: begin
        held_word = w;
        parse_phase = gtsp_pkg::PH_PK_HI;
      end
      gtsp_pkg::PH_PK_HI: begin
        case (desc)
          gtsp_pkg::DESC_XYZF2, gtsp_pkg::DESC_XYZ2, gtsp_pkg::DESC_XYZF3, gtsp_pkg::DESC_XYZ3:
            expect_event(gtsp_pkg::KIND_VERTEX, {4'd0, desc}, held_word, w, '0);
          gtsp_pkg::DESC_FOG:  expect_reg_write(gtsp_pkg::REG_FOG, {56'd0, w[39:32]});
          gtsp_pkg::DESC_AD:   expect_reg_write(w[7:0], held_word);
          gtsp_pkg::DESC_RSVD, gtsp_pkg::DESC_NOP: ;
          default:             expect_reg_write({4'd0, desc}, held_word);
        endcase
        parse_phase = step_descriptor() ? gtsp_pkg::PH_TAG_LO : gtsp_pkg::PH_PK_LO;
      end
      gtsp_pkg::PH_RL: begin
        expect_reg_write({4'd0, desc}, w);
        if (step_descriptor())
          parse_phase = pad_owed ? gtsp_pkg::PH_RL_PAD : gtsp_pkg::PH_TAG_LO;
      end
      gtsp_pkg::PH_IM_LO: begin
        held_word = w;
        parse_phase = gtsp_pkg::PH_IM_HI;
      end
      gtsp_pkg::PH_IM_HI: begin
        if (({1'b0, image_ptr} + gtsp_pkg::QUAD_BYTES) <= gtsp_pkg::VRAM_BYTES)
          expect_event(gtsp_pkg::KIND_IMAGE, 8'd0, held_word, w, image_ptr[21:0]);
        else
          quads_dropped++;
        image_ptr = image_ptr + 32'd16;
        loops_to_go = loops_to_go - 15'd1;
        parse_phase = (loops_to_go == 15'd0) ? gtsp_pkg::PH_TAG_LO : gtsp_pkg::PH_IM_LO;
      end
      default: begin
        pad_owed = 1'b0;
        parse_phase = gtsp_pkg::PH_TAG_LO;
      end
    endcase
    if (last) begin
      parse_phase = gtsp_pkg::PH_TAG_LO;
      buffer_ends++;
    end
  endfunction

  // ---------------- stimulus ----------------

  task automatic push_word(logic [63:0] w, logic last);
    stream_beat_t b;
    b.data = w;
    b.last = last;
    words_to_send.push_back(b);
    words_queued++;
  endtask

  function automatic logic [63:0] make_tag(logic [14:0] nloop, logic pre, logic [10:0] prim,
                                           gtsp_pkg::fmt_t fmt, logic [3:0] nreg);
    logic [63:0] t;
    t = {$urandom, $urandom};
    t[14:0]  = nloop;
    t[46]    = pre;
    t[57:47] = prim;
    t[59:58] = fmt;
    t[63:60] = nreg;
    return t;
  endfunction

  // a single a+d write to bitbltbuf that points the image address at a block
  task automatic set_image_base(logic [13:0] dbp);
    logic [63:0] descs;
    logic [63:0] lo;
    logic [63:0] hi;
    descs = {$urandom, $urandom};
    descs[3:0] = gtsp_pkg::DESC_AD;
    lo = {$urandom, $urandom};
    lo[45:32] = dbp;
    hi = {$urandom, $urandom};
    hi[7:0] = gtsp_pkg::REG_BITBLTBUF;
    push_word(make_tag(15'd1, 1'($urandom_range(1)), 11'($urandom), gtsp_pkg::FMT_PACKED,
                       4'd1), 1'b0);
    push_word(descs, 1'b0);
    push_word(lo, 1'b0);
    push_word(hi, 1'b0);
  endtask

  // whole packet, or cut short with a buffer end on word number cut
  task automatic send_packet(gtsp_pkg::fmt_t fmt, logic [14:0] nloop, logic [3:0] nreg,
                             logic [63:0] descs, int cut, logic close);
    int regs;
    int total;
    int i;
    logic [63:0] w;
    regs = (nreg == 4'd0) ? 16 : int'(nreg);
    case (fmt)
      gtsp_pkg::FMT_PACKED:  total = int'(nloop) * regs * 2;
      gtsp_pkg::FMT_REGLIST: total = int'(nloop) * regs + int'(nloop[0] & regs[0]);
      default:               total = int'(nloop) * 2;
    endcase
    total += 2;
    for (i = 0; i < total && (cut < 0 || i <= cut); i++) begin
      if (i == 0) begin
        w = make_tag(nloop, 1'($urandom_range(1)), 11'($urandom), fmt, nreg);
      end else if (i == 1) begin
        w = descs;
      end else begin
        w = {$urandom, $urandom};
        if (fmt == gtsp_pkg::FMT_PACKED && i[0] && $urandom_range(7) == 0)
          w[7:0] = gtsp_pkg::REG_BITBLTBUF;
      end
      push_word(w, (i == cut) || (close && i == total - 1));
    end
  endtask

  task automatic send_random_sequence();
    int pick;
    int cut;
    int n;
    logic [14:0] nloop;
    logic [3:0] nreg;
    gtsp_pkg::fmt_t fmt;
    pick = $urandom_range(99);
    nreg = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 4));
    nloop = 15'($urandom_range(1, 3));
    cut = -1;
    if (pick >= 88) begin
      n = $urandom_range(1, 4);
      repeat (n - 1) push_word({$urandom, $urandom}, 1'b0);
      push_word({$urandom, $urandom}, 1'b1);
    end else begin
      if (pick < 35) begin
        fmt = gtsp_pkg::FMT_PACKED;
      end else if (pick < 55) begin
        fmt = gtsp_pkg::FMT_REGLIST;
      end else if (pick < 77) begin
        fmt = $urandom_range(1) ? gtsp_pkg::FMT_IMAGE : gtsp_pkg::FMT_DISABLE;
        if ($urandom_range(1)) begin
          case ($urandom_range(2))
            0:       set_image_base(14'($urandom_range(2047)));
            1:       set_image_base(14'd2047);
            default: set_image_base(14'($urandom_range(2048, 16383)));
          endcase
        end
      end else begin
        fmt = gtsp_pkg::fmt_t'($urandom_range(3));
        nloop = 15'd0;
      end
      if ($urandom_range(5) == 0) begin
        cut = $urandom_range(0, 40);
        if ($urandom_range(1))
          nloop = 15'($urandom_range(32767));
      end
      send_packet(fmt, nloop, nreg, {$urandom, $urandom}, cut, $urandom_range(4) == 0);
    end
  endtask

  task automatic wait_until_sent();
    while (words_to_send.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int chunk_end;
    logic [63:0] descs;
    logic [63:0] w;
    rst = 1'b1;
    word_ch.valid = 1'b0;
    word_ch.word = '0;
    word_ch.last_of_buffer = 1'b0;
    event_ch.ready = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 67;
    stall_request = 1'b0;

    // tag cut short by a buffer end
    push_word('1, 1'b1);
    // zero loops with the widest prim preset
    push_word(make_tag(15'd0, 1'b1, 11'h7FF, gtsp_pkg::FMT_PACKED, 4'd0), 1'b0);
    push_word('0, 1'b0);
    // packed quads through plain, vertex, fog, reserved, a+d and nop descriptors
    descs = {$urandom, $urandom};
    descs[23:0] = {gtsp_pkg::DESC_NOP, gtsp_pkg::DESC_AD, gtsp_pkg::DESC_RSVD,
                   gtsp_pkg::DESC_FOG, gtsp_pkg::DESC_XYZF2, gtsp_pkg::REG_PRIM[3:0]};
    push_word(make_tag(15'd1, 1'b1, 11'd0, gtsp_pkg::FMT_PACKED, 4'd6), 1'b0);
    push_word(descs, 1'b0);
    push_word('0, 1'b0);
    push_word('1, 1'b0);
    push_word('1, 1'b0);
    push_word('1, 1'b0);
    push_word({$urandom, $urandom}, 1'b0);
    push_word({$urandom, $urandom}, 1'b0);
    push_word({$urandom, $urandom}, 1'b0);
    push_word({$urandom, $urandom}, 1'b0);
    w = {$urandom, $urandom};
    w[45:32] = 14'd2047;
    push_word(w, 1'b0);
    w = {$urandom, $urandom};
    w[7:0] = gtsp_pkg::REG_BITBLTBUF;
    push_word(w, 1'b0);
    push_word({$urandom, $urandom}, 1'b0);
    push_word({$urandom, $urandom}, 1'b0);
    // one image quad near the end of memory
    push_word(make_tag(15'd1, 1'b0, 11'd0, gtsp_pkg::FMT_IMAGE, 4'd1), 1'b0);
    push_word({$urandom, $urandom}, 1'b0);
    push_word({$urandom, $urandom}, 1'b0);
    push_word({$urandom, $urandom}, 1'b0);
    // reglist with odd word count, so one padding word
    descs = {$urandom, $urandom};
    descs[3:0] = gtsp_pkg::DESC_NOP;
    push_word(make_tag(15'd1, 1'b0, 11'd0, gtsp_pkg::FMT_REGLIST, 4'd1), 1'b0);
    push_word(descs, 1'b0);
    push_word('1, 1'b0);
    push_word({$urandom, $urandom}, 1'b0);

    chunk_end = words_queued + RANDOM_CHUNK;
    while (words_queued < chunk_end)
      send_random_sequence();

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    wait_until_sent();

    send_idle_pct = 67;
    recv_idle_pct = 8;
    chunk_end = words_queued + RANDOM_CHUNK;
    while (words_queued < chunk_end)
      send_random_sequence();
    wait_until_sent();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // walk image writes across the end of memory
    set_image_base(14'd2047);
    send_packet(gtsp_pkg::FMT_IMAGE, 15'd129, 4'd1, {$urandom, $urandom}, -1, 1'b0);
    chunk_end = words_queued + RANDOM_CHUNK;
    while (words_queued < chunk_end)
      send_random_sequence();
    stall_request = 1'b1;
    wait_until_sent();

    do @(negedge clk); while (!all_settled);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d stream words, %0d buffer ends: %0d register writes, %0d vertex",
             words_parsed, buffer_ends, reg_writes, vertex_events);
    $display("events, %0d image quads written and %0d dropped past the end of memory",
             image_writes, quads_dropped);
    if (mismatches == 0) begin
      $display("gif_tag_stream_parser_core: match");
    end else begin
      $display("gif_tag_stream_parser_core: mismatch");
    end
    $finish;
  end

  // ---------------- driver ----------------

  always @(negedge clk) begin
    stream_beat_t b;
    if (rst) begin
      word_ch.valid <= 1'b0;
    end else if (!word_ch.valid || word_taken) begin
      if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        b = words_to_send.pop_front();
        word_ch.valid <= 1'b1;
        word_ch.word <= b.data;
        word_ch.last_of_buffer <= b.last;
      end else begin
        word_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------

  always @(negedge clk) begin
    int stall_left;
    logic stall_started;
    if (rst) begin
      stall_left = 0;
      stall_started = 1'b0;
      event_ch.ready <= 1'b0;
    end else begin
      if (stall_request && !stall_started) begin
        stall_started = 1'b1;
        stall_left = STALL_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        event_ch.ready <= 1'b0;
      end else begin
        event_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    event_rec_t want;
    if (rst) begin
      word_taken <= 1'b0;
      all_settled <= 1'b0;
    end else begin
      if (event_ch.valid && event_ch.ready) begin
        if (awaited_events.size() == 0) begin
          report_mismatch($sformatf("kind %0d event at %h with nothing predicted",
                                    event_ch.kind, event_ch.reg_addr));
        end else begin
          want = awaited_events.pop_front();
          if (event_ch.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, predicted %0d", event_ch.kind, want.kind));
          if (event_ch.reg_addr !== want.reg_addr)
            report_mismatch($sformatf("reg_addr %h, predicted %h",
                                      event_ch.reg_addr, want.reg_addr));
          if (event_ch.value !== want.value)
            report_mismatch($sformatf("value %h, predicted %h", event_ch.value, want.value));
          if (event_ch.value_hi !== want.value_hi)
            report_mismatch($sformatf("value_hi %h, predicted %h",
                                      event_ch.value_hi, want.value_hi));
          if (event_ch.vram_addr !== want.vram_addr)
            report_mismatch($sformatf("vram_addr %h, predicted %h",
                                      event_ch.vram_addr, want.vram_addr));
        end
      end
      if (word_ch.valid && word_ch.ready)
        parse_stream_word(word_ch.word, word_ch.last_of_buffer);
      word_taken <= word_ch.valid && word_ch.ready;
      all_settled <= words_to_send.size() == 0 && !(word_ch.valid && !word_ch.ready)
                     && awaited_events.size() == 0;
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (rst || (word_ch.valid && word_ch.ready) || (event_ch.valid && event_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("no beat on either channel for %0d cycles, %0d events still awaited",
               QUIET_LIMIT, awaited_events.size());
      $display("gif_tag_stream_parser_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
